[hdl/fttp_pkg.sv]
package fttp_pkg;

    localparam int LEN_EXT = 41;
    localparam int LEN_STD = 29;
    localparam int CNT_W = 6;

    localparam logic [7:0] MSG_TYPE = 8'hD1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_TYPE = 2'd1;
    localparam logic [1:0] ST_BAD_XOR  = 2'd2;
    localparam logic [1:0] ST_BAD_LEN  = 2'd3;

    localparam int TDATA_W = 232;
    localparam int TUSER_W = 3;

    typedef logic [LEN_EXT-1:0][7:0] byte_line_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] pan_angle;
        logic [31:0] tilt_angle;
        logic [31:0] roll_angle;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [15:0] zoom_value;
        logic [15:0] focus_value;
        logic [3:0]  device_id;
        logic        extended_format;
        logic [1:0]  parse_status;
    } result_t;

endpackage

[hdl/fttp_in_reg.sv]
module fttp_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  fttp_pkg::in_beat_t s_beat,
    output logic              beat_valid,
    output fttp_pkg::in_beat_t beat,
    input  logic              beat_taken
);
    import fttp_pkg::*;

    logic     valid_reg;
    in_beat_t beat_reg;

    assign s_tready   = !valid_reg || beat_taken;
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            beat_reg <= s_beat;
        end
    end

endmodule

[hdl/fttp_parse.sv]
module fttp_parse (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               beat_valid,
    input  fttp_pkg::in_beat_t beat,
    input  logic               out_free,
    output logic               beat_taken,
    output logic               done,
    output fttp_pkg::result_t  result
);
    import fttp_pkg::*;

    localparam logic [CNT_W-1:0] CNT_EXT = CNT_W'(LEN_EXT);
    localparam logic [CNT_W-1:0] CNT_STD = CNT_W'(LEN_STD);

    byte_line_t       line_reg;
    byte_line_t       line_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       xor_reg;
    logic [7:0]       xor_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             is_ext;
    logic [7:0]       type_byte;
    logic [1:0]       status;

    function automatic logic [31:0] be32(input byte_line_t l, input int top);
        be32 = {l[top], l[top-1], l[top-2], l[top-3]};
    endfunction

    function automatic logic [31:0] be24s(input byte_line_t l, input int top);
        be24s = {l[top], l[top-1], l[top-2], 8'h00};
    endfunction

    function automatic logic [15:0] be16(input byte_line_t l, input int top);
        be16 = {l[top], l[top-1]};
    endfunction

    assign beat_taken = beat_valid && (!beat.last_byte || out_free);
    assign done       = beat_taken && beat.last_byte;

    // newest byte at tap 0; packet byte k sits at tap (len - 1 - k)
    assign line_next  = {line_reg[LEN_EXT-2:0], beat.data_byte};
    assign count_next = (count_reg < CNT_EXT) ? count_reg + CNT_W'(1) : count_reg;
    assign ovf_next   = ovf_reg || (count_reg == CNT_EXT);
    assign xor_next   = xor_reg ^ beat.data_byte;
    assign is_ext     = (count_next == CNT_EXT);
    assign type_byte  = is_ext ? line_next[LEN_EXT-1] : line_next[LEN_STD-1];

    always_comb
    begin
        if (ovf_next || (count_next != CNT_EXT && count_next != CNT_STD))
        begin
            status = ST_BAD_LEN;
        end
        else if (type_byte != MSG_TYPE)
        begin
            status = ST_BAD_TYPE;
        end
        else if (is_ext && xor_next != 8'h00)
        begin
            status = ST_BAD_XOR;
        end
        else
        begin
            status = ST_OK;
        end
    end

    always_comb
    begin
        result = '0;
        if (status == ST_OK)
        begin
            if (is_ext)
            begin
                result.pan_angle       = be32(line_next, 13);
                result.tilt_angle      = be32(line_next, 9);
                result.roll_angle      = be32(line_next, 5);
                result.pos_x           = be32(line_next, 30);
                result.pos_y           = be32(line_next, 26);
                result.pos_z           = be32(line_next, 22);
                result.zoom_value      = be16(line_next, 18);
                result.focus_value     = be16(line_next, 16);
                result.device_id       = line_next[1][7:4];
                result.extended_format = 1'b1;
            end
            else
            begin
                result.pan_angle       = be24s(line_next, 27);
                result.tilt_angle      = be24s(line_next, 24);
                result.roll_angle      = be24s(line_next, 21);
                result.pos_x           = be32(line_next, 18);
                result.pos_y           = be32(line_next, 14);
                result.pos_z           = be32(line_next, 10);
                result.zoom_value      = be16(line_next, 6);
                result.focus_value     = be16(line_next, 4);
                result.device_id       = line_next[2][7:4];
                result.extended_format = 1'b0;
            end
        end
        result.parse_status = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            xor_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (beat_taken)
        begin
            if (beat.last_byte)
            begin
                count_reg <= '0;
                xor_reg   <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                count_reg <= count_next;
                xor_reg   <= xor_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat_taken)
        begin
            line_reg <= line_next;
        end
    end

endmodule

[hdl/freed_tracking_packet_parser_core.sv]
// Camera tracking packet parser (D1 message, 29-byte standard, 41-byte extended).
// Slave stream: one packet byte per beat in wire order, tlast on the final byte.
// Master stream: one result beat per packet, issued on the final byte.
// Every input beat is registered, then shifted into a 41-tap byte line with a
// running XOR and a saturating byte count. The final beat decodes straight from
// the line taps into the output register.
// Throughput: one byte per cycle, except that a final byte waits while the
// receiver stalls. A final byte leaves the input register into the output register.
// Status: 0 ok, 1 wrong type byte, 2 bad XOR (extended only), 3 bad length.
// Any error zeroes all fields except the status.
// Reset clears the count, XOR, overflow flag and both valid flags; the byte
// line is not cleared since a decode only reads bytes of the current packet.
// When the receiver stalls, the pending result holds in the output register;
// non-final bytes keep flowing, and a final byte waits in the input register
// until the output register frees up.
module freed_tracking_packet_parser_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,  // data_byte
    input  logic                          s_tlast,  // last_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // pan_angle, tilt_angle, roll_angle, pos_x, pos_y, pos_z, zoom_value,
    // focus_value, device_id, zero pad
    output logic [fttp_pkg::TDATA_W-1:0] m_tdata,
    output logic [fttp_pkg::TUSER_W-1:0] m_tuser   // extended_format, parse_status
);
    import fttp_pkg::*;

    in_beat_t s_beat;
    in_beat_t beat;
    logic     beat_valid;
    logic     beat_taken;
    logic     done;
    logic     out_free;
    result_t  result;
    logic     out_valid_reg;
    result_t  out_reg;

    assign s_beat.data_byte = s_tdata;
    assign s_beat.last_byte = s_tlast;
    assign out_free = !out_valid_reg || m_tready;

    fttp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_beat     (s_beat),
        .beat_valid (beat_valid),
        .beat       (beat),
        .beat_taken (beat_taken)
    );

    fttp_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_valid (beat_valid),
        .beat       (beat),
        .out_free   (out_free),
        .beat_taken (beat_taken),
        .done       (done),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'h0, out_reg.device_id, out_reg.focus_value, out_reg.zoom_value,
                       out_reg.pos_z, out_reg.pos_y, out_reg.pos_x,
                       out_reg.roll_angle, out_reg.tilt_angle, out_reg.pan_angle};
    assign m_tuser  = {out_reg.parse_status, out_reg.extended_format};

endmodule

[tb/tb_freed_tracking_packet_parser_core.sv]
module tb_freed_tracking_packet_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    import fttp_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_START  = 600;
    localparam int HOLD_LEN    = 300;
    localparam int MIN_BYTES   = 750;

    typedef enum int {
        PK_STD,
        PK_EXT,
        PK_EXT_BADSUM,
        PK_BAD_TYPE,
        PK_ODD_LEN,
        PK_LONG
    } packet_kind_e;

    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_SPARSE
    } rx_mode_e;

    // predicts the decoded pose for each accepted packet and checks results in order
    class pose_tracker;
        logic [7:0] line [LEN_EXT];
        int         count;
        logic [7:0] xsum;
        bit         overflow;
        result_t    expected_poses [$];
        int         failures;
        int         bytes_seen;
        int         packets_seen;
        int         per_status [4];
        int         ext_ok;

        function new();
            count        = 0;
            xsum         = 8'h00;
            overflow     = 1'b0;
            failures     = 0;
            bytes_seen   = 0;
            packets_seen = 0;
            ext_ok       = 0;
            foreach (per_status[i])
                per_status[i] = 0;
        endfunction

        function logic [31:0] be32(int at);
            return {line[at], line[at+1], line[at+2], line[at+3]};
        endfunction

        // 24-bit angle moved to the top bits, scale x256
        function logic [31:0] be24_up(int at);
            return {line[at], line[at+1], line[at+2], 8'h00};
        endfunction

        function logic [15:0] be16(int at);
            return {line[at], line[at+1]};
        endfunction

        function void note_byte(logic [7:0] b, logic lst);
            result_t    want;
            bit         ext;
            logic [1:0] st;
            bytes_seen++;
            if (count < LEN_EXT)
            begin
                line[count] = b;
                count++;
            end
            else
                overflow = 1'b1;
            xsum ^= b;
            if (!lst)
                return;

            want = '0;
            ext  = (count == LEN_EXT);
            if (overflow || (count != LEN_EXT && count != LEN_STD))
                st = ST_BAD_LEN;
            else if (line[0] != MSG_TYPE)
                st = ST_BAD_TYPE;
            else if (ext && xsum != 8'h00)
                st = ST_BAD_XOR;
            else
                st = ST_OK;

            if (st == ST_OK)
            begin
                if (ext)
                begin
                    want.pan_angle       = be32(27);
                    want.tilt_angle      = be32(31);
                    want.roll_angle      = be32(35);
                    want.device_id       = line[39][7:4];
                    want.extended_format = 1'b1;
                    ext_ok++;
                end
                else
                begin
                    want.pan_angle  = be24_up(1);
                    want.tilt_angle = be24_up(4);
                    want.roll_angle = be24_up(7);
                    want.device_id  = line[26][7:4];
                end
                want.pos_x       = be32(10);
                want.pos_y       = be32(14);
                want.pos_z       = be32(18);
                want.zoom_value  = be16(22);
                want.focus_value = be16(24);
            end
            want.parse_status = st;
            per_status[st]++;
            packets_seen++;
            expected_poses.push_back(want);

            count    = 0;
            xsum     = 8'h00;
            overflow = 1'b0;
        endfunction

        function int pending();
            return expected_poses.size();
        endfunction

        function void field_check(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %h, actual %h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(logic [TDATA_W-1:0] td, logic [TUSER_W-1:0] tu);
            result_t want;
            if (expected_poses.size() == 0)
            begin
                $error("result beat with no packet pending: tdata %h tuser %h", td, tu);
                failures++;
                return;
            end
            want = expected_poses.pop_front();
            field_check("pan_angle",       want.pan_angle,       td[31:0]);
            field_check("tilt_angle",      want.tilt_angle,      td[63:32]);
            field_check("roll_angle",      want.roll_angle,      td[95:64]);
            field_check("pos_x",           want.pos_x,           td[127:96]);
            field_check("pos_y",           want.pos_y,           td[159:128]);
            field_check("pos_z",           want.pos_z,           td[191:160]);
            field_check("zoom_value",      32'(want.zoom_value),  32'(td[207:192]));
            field_check("focus_value",     32'(want.focus_value), 32'(td[223:208]));
            field_check("device_id",       32'(want.device_id),   32'(td[227:224]));
            field_check("tdata_pad",       32'(4'h0),             32'(td[231:228]));
            field_check("extended_format", 32'(want.extended_format), 32'(tu[0]));
            field_check("parse_status",    32'(want.parse_status),    32'(tu[2:1]));
        endfunction
    endclass

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata  = 8'h00;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic [TUSER_W-1:0]   m_tuser;

    pose_tracker board;
    int          burst_left = 0;
    int          bytes_sent = 0;
    int          quiet_cycles = 0;
    int          rx_cycle = 0;
    int          rx_mode_left = 0;
    rx_mode_e    rx_mode = RX_FREE;

    freed_tracking_packet_parser_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            board.note_byte(s_tdata, s_tlast);
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser);
    end

    // receiver: changing stall patterns, plus one long hold-off to back up the input
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rx_cycle++;
            if (rx_mode_left == 0)
            begin
                rx_mode      = rx_mode_e'($urandom_range(0, 2));
                rx_mode_left = $urandom_range(20, 120);
            end
            else
                rx_mode_left--;
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
                m_tready <= 1'b0;
            else
                case (rx_mode)
                    RX_FREE:  m_tready <= 1'b1;
                    RX_COIN:  m_tready <= 1'($urandom_range(0, 1));
                    default:  m_tready <= ($urandom_range(0, 3) == 0);
                endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: nothing accepted for %0d cycles", QUIET_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic lst);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_packet(input packet_kind_e kind);
        logic [7:0] pkt [$];
        logic [7:0] v;
        logic [7:0] sum;
        int         len;
        int         style;
        case (kind)
            PK_STD:        len = LEN_STD;
            PK_EXT:        len = LEN_EXT;
            PK_EXT_BADSUM: len = LEN_EXT;
            PK_BAD_TYPE:   len = $urandom_range(0, 1) ? LEN_STD : LEN_EXT;
            PK_LONG:       len = $urandom_range(LEN_EXT + 1, 70);
            default:
            begin
                len = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(1, 60);
                if (len == LEN_STD || len == LEN_EXT)
                    len++;
            end
        endcase

        // corner style pushes sign bits and all-ones/all-zeros into the fields
        style = $urandom_range(0, 3);
        for (int i = 0; i < len; i++)
        begin
            if (style == 1)
                case ($urandom_range(0, 3))
                    0:       v = 8'h00;
                    1:       v = 8'hFF;
                    2:       v = 8'h80;
                    default: v = 8'h7F;
                endcase
            else
                v = 8'($urandom_range(0, 255));
            pkt.push_back(v);
        end

        if (kind == PK_BAD_TYPE)
        begin
            do
                v = 8'($urandom_range(0, 255));
            while (v == MSG_TYPE);
            pkt[0] = v;
        end
        else if ((kind != PK_ODD_LEN && kind != PK_LONG) || $urandom_range(0, 1))
            pkt[0] = MSG_TYPE;

        if (kind == PK_EXT || kind == PK_EXT_BADSUM)
        begin
            sum = 8'h00;
            for (int i = 0; i < LEN_EXT - 1; i++)
                sum ^= pkt[i];
            pkt[LEN_EXT-1] = (kind == PK_EXT) ? sum : sum ^ 8'($urandom_range(1, 255));
        end

        for (int i = 0; i < len; i++)
            push_byte(pkt[i], i == len - 1);
    endtask

    initial
    begin
        int r;
        board = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short packets: single bytes, two bytes, corner byte values
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(MSG_TYPE, 1'b1);
        push_byte(MSG_TYPE, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h7F, 1'b1);

        for (int k = PK_STD; k <= PK_LONG; k++)
            send_packet(packet_kind_e'(k));

        while (bytes_sent < MIN_BYTES)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                send_packet(PK_STD);
            else if (r < 60)
                send_packet(PK_EXT);
            else if (r < 70)
                send_packet(PK_EXT_BADSUM);
            else if (r < 80)
                send_packet(PK_BAD_TYPE);
            else if (r < 93)
                send_packet(PK_ODD_LEN);
            else
                send_packet(PK_LONG);
        end
        s_tvalid <= 1'b0;
        @(posedge clk);

        while (board.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Run covered %0d bytes in %0d packets: %0d standard and %0d extended decoded,",
                 board.bytes_seen, board.packets_seen,
                 board.per_status[ST_OK] - board.ext_ok, board.ext_ok);
        $display("  %0d wrong type, %0d bad checksum, %0d bad length (incl. oversize)",
                 board.per_status[ST_BAD_TYPE], board.per_status[ST_BAD_XOR],
                 board.per_status[ST_BAD_LEN]);
        if (board.failures == 0 && board.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
